[rtl/mra_pkg.sv]
// ----------------------------------------------------------------------------
// mra_pkg
// Shared types and constants of the message reassembly admission block.
// ----------------------------------------------------------------------------
package mra_pkg;

  localparam int ENTRIES     = 16;  // store entries, 1 to 64
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCAN_W      = $clog2(ENTRIES + 1);
  localparam int MAX_RESULTS = 16;  // expire notices per tick
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int FB_BITS     = 8;

  localparam logic [1:0] OP_ARRIVE  = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [1:0] CFG_MAX    = 2'd0;
  localparam logic [1:0] CFG_THR    = 2'd1;
  localparam logic [1:0] CFG_DEADLN = 2'd2;

  localparam logic [2:0] K_ACCEPT   = 3'd0;
  localparam logic [2:0] K_NOTICE   = 3'd1;
  localparam logic [2:0] K_SILENT   = 3'd2;
  localparam logic [2:0] K_COMPLETE = 3'd3;
  localparam logic [2:0] K_EXPIRED  = 3'd4;
  localparam logic [2:0] K_RELEASED = 3'd5;
  localparam logic [2:0] K_STFULL   = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] src_id;
    logic [31:0] message_id;
    logic [15:0] msg_len;
    logic [15:0] seqno;
    logic [15:0] tx_queue_len;
    logic [15:0] release_len;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] src;
    logic [31:0] msg_id;
    logic        rx_congested;
    logic        tx_congested;
    logic [7:0]  feedback;
    logic [15:0] len;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DEC, S_DSTART, S_DWAIT, S_TICK, S_EMIT
  } state_t;

endpackage

[rtl/mra_div.sv]
// ----------------------------------------------------------------------------
// mra_div
// Feedback divider: min(255, floor(256*num/den)), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mra_div import mra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [7:0]  q
);

  logic [16:0] rem_r;
  logic [7:0]  q_r;
  logic [3:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] shl;

  assign shl = {rem_r[15:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (num >= den) begin
          q_r    <= '1;      // saturates, also covers zero capacity
          done_r <= 1'b1;
        end else begin
          rem_r  <= {1'b0, num};
          q_r    <= '0;
          step_r <= 4'(FB_BITS);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (shl >= {1'b0, den}) begin
          rem_r <= shl - {1'b0, den};
          q_r   <= {q_r[6:0], 1'b1};
        end else begin
          rem_r <= shl;
          q_r   <= {q_r[6:0], 1'b0};
        end
        step_r <= step_r - 4'd1;
        if (step_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[rtl/mra_front.sv]
// ----------------------------------------------------------------------------
// mra_front
// Input side: accepts transactions into a two-deep queue for the engine.
// ----------------------------------------------------------------------------
module mra_front import mra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t push_item,
  output logic  valid,
  input  logic  pop,
  output item_t head
);

  item_t      mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/mra_outq.sv]
// ----------------------------------------------------------------------------
// mra_outq
// Result queue, four deep, between the engine and the result port.
// ----------------------------------------------------------------------------
module mra_outq import mra_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t head
);

  res_t       mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 2'd1;
      if (do_pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

endmodule

[rtl/mra_back.sv]
// ----------------------------------------------------------------------------
// mra_back
// Engine: key store, occupancy accounting, tick scan and result building.
// ----------------------------------------------------------------------------
module mra_back import mra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  item_t       in_head,
  output logic        in_pop,
  output logic        res_push,
  output res_t        res,
  input  logic        res_full
);

  state_t state_r, state_nxt;

  logic [15:0] max_r, thr_r, dl_r, occ_r;
  item_t       item_r;

  logic        valid_r [ENTRIES];
  logic [63:0] key_r   [ENTRIES];
  logic [15:0] cnt_r   [ENTRIES];
  logic [15:0] len_r   [ENTRIES];
  logic [15:0] tmr_r   [ENTRIES];

  logic             hit_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;
  logic             hit_c, free_c;
  logic [IDX_W-1:0] hit_idx_c, free_idx_c;

  logic [SCAN_W-1:0] scan_r;
  logic [NRES_W-1:0] nres_r;

  // pending result; in a tick scan it is pushed once the next one (or the end) is known
  logic        pend_v_r, pend_force_r;
  logic [2:0]  pend_kind_r;
  logic [63:0] pend_key_r;
  logic [7:0]  pend_fb_r;
  logic [15:0] pend_len_r;

  logic             div_start, div_done;
  logic [7:0]       div_q;
  logic [IDX_W-1:0] sidx;
  logic             scan_end, due, cap_ok, push_last;
  logic [15:0]      cnt_inc;
  logic             complete;
  logic [16:0]      sum;
  logic             nofit;
  logic [63:0]      key;
  int               i;

  mra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (occ_r),
    .den   (max_r),
    .done  (div_done),
    .q     (div_q)
  );

  assign key      = {item_r.src_id, item_r.message_id};
  assign sidx     = scan_r[IDX_W-1:0];
  assign scan_end = (scan_r == SCAN_W'(ENTRIES));
  assign due      = !scan_end && valid_r[sidx] && (tmr_r[sidx] <= 16'd1);
  assign cap_ok   = (nres_r < NRES_W'(MAX_RESULTS));
  assign cnt_inc  = cnt_r[hit_idx_r] + 16'd1;
  assign complete = (cnt_inc == len_r[hit_idx_r]);
  assign sum      = {1'b0, occ_r} + {1'b0, item_r.msg_len};
  assign nofit    = sum > {1'b0, max_r};

  // parallel key match and lowest free entry
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (i = 0; i < ENTRIES; i++) begin
      if (valid_r[i]) begin
        if (!hit_c && key_r[i] == key) begin
          hit_c     = 1'b1;
          hit_idx_c = IDX_W'(i);
        end
      end else if (!free_c) begin
        free_c     = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_head.op)
            OP_ARRIVE:  state_nxt = S_LOOK;
            OP_TICK:    state_nxt = S_TICK;
            OP_RELEASE: state_nxt = S_EMIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: state_nxt = S_DEC;
      S_DEC: begin
        if ((hit_r && complete) || (!hit_r && !nofit && item_r.msg_len == 16'd1)) begin
          state_nxt = S_DSTART;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_done) state_nxt = S_EMIT;
      S_TICK:   if (scan_end && (!pend_v_r || !res_full)) state_nxt = S_IDLE;
      S_EMIT:   if (!res_full) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_pop    = 1'b0;
    res_push  = 1'b0;
    div_start = 1'b0;
    push_last = 1'b1;
    unique case (state_r)
      S_IDLE:   in_pop = in_valid;
      S_DSTART: div_start = 1'b1;
      S_EMIT:   res_push = !res_full;
      S_TICK: begin
        push_last = scan_end;
        res_push  = pend_v_r && !res_full && (scan_end || (due && cap_ok));
      end
      default: ;
    endcase
  end

  assign res.kind         = pend_kind_r;
  assign res.src          = pend_key_r[63:32];
  assign res.msg_id       = pend_key_r[31:0];
  assign res.rx_congested = pend_force_r || (occ_r >= thr_r);
  assign res.tx_congested = (item_r.tx_queue_len >= thr_r);
  assign res.feedback     = pend_fb_r;
  assign res.len          = pend_len_r;
  assign res.last         = push_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      max_r    <= 16'd1024;
      thr_r    <= 16'd512;
      dl_r     <= 16'd28000;
      occ_r    <= '0;
      pend_v_r <= 1'b0;
      scan_r   <= '0;
      nres_r   <= '0;
      for (int e = 0; e < ENTRIES; e++) valid_r[e] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX:    max_r <= cfg_wdata;
          CFG_THR:    thr_r <= cfg_wdata;
          CFG_DEADLN: dl_r  <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r   <= in_head;
            scan_r   <= '0;
            nres_r   <= '0;
            pend_v_r <= 1'b0;
            if (in_head.op == OP_RELEASE) begin
              occ_r        <= (occ_r > in_head.release_len) ?
                              occ_r - in_head.release_len : 16'd0;
              pend_kind_r  <= K_RELEASED;
              pend_key_r   <= {in_head.src_id, in_head.message_id};
              pend_force_r <= 1'b0;
              pend_fb_r    <= '0;
              pend_len_r   <= '0;
            end
          end
        end
        S_LOOK: begin
          hit_r      <= hit_c;
          hit_idx_r  <= hit_idx_c;
          free_r     <= free_c;
          free_idx_r <= free_idx_c;
        end
        S_DEC: begin
          pend_key_r   <= key;
          pend_fb_r    <= '0;
          pend_len_r   <= '0;
          pend_force_r <= 1'b0;
          if (hit_r) begin
            cnt_r[hit_idx_r] <= cnt_inc;
            if (complete) begin
              valid_r[hit_idx_r] <= 1'b0;
              pend_kind_r        <= K_COMPLETE;
              pend_len_r         <= len_r[hit_idx_r];
            end else begin
              pend_kind_r <= K_ACCEPT;
            end
          end else if (nofit) begin
            pend_kind_r  <= (item_r.seqno == 16'd0) ? K_NOTICE : K_SILENT;
            pend_force_r <= 1'b1;
          end else if (item_r.msg_len == 16'd1) begin
            occ_r       <= occ_r + 16'd1;
            pend_kind_r <= K_COMPLETE;
            pend_len_r  <= 16'd1;
          end else if (!free_r) begin
            pend_kind_r  <= K_STFULL;
            pend_force_r <= 1'b1;
          end else begin
            occ_r                <= sum[15:0];
            valid_r[free_idx_r]  <= 1'b1;
            key_r[free_idx_r]    <= key;
            cnt_r[free_idx_r]    <= 16'd1;
            len_r[free_idx_r]    <= item_r.msg_len;
            tmr_r[free_idx_r]    <= dl_r;
            pend_kind_r          <= K_ACCEPT;
          end
        end
        S_DWAIT: if (div_done) pend_fb_r <= div_q;
        S_TICK: begin
          if (!scan_end) begin
            if (due) begin
              if (!cap_ok) begin
                tmr_r[sidx] <= 16'd1;
                scan_r      <= scan_r + SCAN_W'(1);
              end else if (!pend_v_r || !res_full) begin
                valid_r[sidx] <= 1'b0;
                occ_r         <= (occ_r > len_r[sidx]) ? occ_r - len_r[sidx] : 16'd0;
                pend_v_r      <= 1'b1;
                pend_kind_r   <= K_EXPIRED;
                pend_key_r    <= key_r[sidx];
                pend_force_r  <= 1'b1;
                pend_fb_r     <= '0;
                pend_len_r    <= '0;
                nres_r        <= nres_r + NRES_W'(1);
                scan_r        <= scan_r + SCAN_W'(1);
              end
            end else begin
              if (valid_r[sidx]) tmr_r[sidx] <= tmr_r[sidx] - 16'd1;
              scan_r <= scan_r + SCAN_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into a full queue");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= SCAN_W'(ENTRIES)) else $error("tick scan ran past the store");
  a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= NRES_W'(MAX_RESULTS)) else $error("too many expire notices");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_pop |-> (state_r == S_IDLE) && in_valid) else $error("pop outside idle");

endmodule

[rtl/message_reassembly_admission.sv]
// ----------------------------------------------------------------------------
// message_reassembly_admission
// Admits message packets against a reserved buffer and reports outcomes.
// ----------------------------------------------------------------------------
// Use: both channels behave as queues. Push an input transaction while full
// is low; take results while empty is low by raising pop. Op arrival looks
// up (src_id, message_id) in a 16-entry store and yields one result; op
// release yields one result; op tick scans every entry, one per cycle while
// results can be queued, and yields one result per expired message (none if
// nothing is due); op 3 is dropped. The last result of a transaction has
// last set. In the engine an arrival passes look, decide and emit, with the
// 8-step feedback divider before emit when it completes a message (no steps
// when the feedback saturates); a release goes straight to emit; a tick scans
// the store. A two-deep input queue and a four-deep result queue decouple
// both sides, so input is taken while results wait. Reset (synchronous,
// rst_n low) empties both queues, clears the store and occupancy and loads
// the register defaults. A stalled receiver fills the result queue, then
// the engine waits, then full rises on the input. Configuration writes
// take effect at once; making them while idle is left to the user.
// ----------------------------------------------------------------------------
module message_reassembly_admission import mra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_src_id,
  input  logic [31:0] in_message_id,
  input  logic [15:0] in_msg_len,
  input  logic [15:0] in_seqno,
  input  logic [15:0] in_tx_queue_len,
  input  logic [15:0] in_release_len,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [31:0] out_src_out,
  output logic [31:0] out_msg_id_out,
  output logic        out_rx_congested,
  output logic        out_tx_congested,
  output logic [7:0]  out_feedback,
  output logic [15:0] out_len_out,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  item_t in_item, head;
  logic  head_valid, head_pop;
  logic  res_push, res_full;
  res_t  res, out_res;

  assign in_item = '{op: in_op, src_id: in_src_id, message_id: in_message_id,
                     msg_len: in_msg_len, seqno: in_seqno,
                     tx_queue_len: in_tx_queue_len, release_len: in_release_len};

  // front: accept and hold transactions
  mra_front u_front (
    .clk (clk), .rst_n (rst_n),
    .push (in_push), .full (in_full), .push_item (in_item),
    .valid (head_valid), .pop (head_pop), .head (head)
  );

  // back: store, accounting and result building
  mra_back u_back (
    .clk (clk), .rst_n (rst_n),
    .cfg_we (cfg_we), .cfg_index (cfg_index), .cfg_wdata (cfg_wdata),
    .in_valid (head_valid), .in_head (head), .in_pop (head_pop),
    .res_push (res_push), .res (res), .res_full (res_full)
  );

  // result queue toward the receiver
  mra_outq u_outq (
    .clk (clk), .rst_n (rst_n),
    .push (res_push), .push_res (res), .full (res_full),
    .empty (out_empty), .pop (out_pop), .head (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_src_out      = out_res.src;
  assign out_msg_id_out   = out_res.msg_id;
  assign out_rx_congested = out_res.rx_congested;
  assign out_tx_congested = out_res.tx_congested;
  assign out_feedback     = out_res.feedback;
  assign out_len_out      = out_res.len;
  assign out_last         = out_res.last;

endmodule
